@@ rtl/assert_macros.svh @@
// Assertion macros used by the RTL top module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every rising clock edge outside of reset.
`define DEOF_ASSERT(name, prop) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("deof assertion failed");

// The condition must never be true at a rising clock edge outside of reset.
`define DEOF_ASSERT_NEVER(name, cond) \
	name: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error("deof forbidden condition seen");

`endif

@@ rtl/deof_pkg.sv @@
`default_nettype none

package deof_pkg;

	localparam int FRAC_BITS = 15;
	localparam int ENV_W = FRAC_BITS + 1;
	localparam int CNT_W = $clog2(FRAC_BITS + 1);
	localparam logic [ENV_W-1:0] UNIT_LEVEL = ENV_W'(1) << FRAC_BITS;

	localparam int AMP_W = 16;
	localparam int RATE_W = 16;
	localparam int BIAS_W = 15;
	localparam int GAIN_W = 16;
	localparam int OUT_W = 16;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 16;

	localparam int RATE_FRAC = 16;
	localparam int BIAS_FRAC = 14;
	localparam int GAIN_SHIFT = 26;
	localparam int SMOOTH_SHIFT = 16;

	localparam int MUL_A_W = 32;
	localparam int MUL_B_W = 18;
	localparam int PROD_W = MUL_A_W + MUL_B_W;
	localparam int ACC_W = 33;

	localparam logic [RATE_W-1:0] SMOOTH_OLD = 16'd38011;
	localparam logic [RATE_W-1:0] SMOOTH_NEW = 16'd27525;

	localparam logic CMD_UPDATE = 1'b0;
	localparam logic CMD_CLEAR = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_LEVEL_SCALE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FAST_RISE = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FAST_FALL = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SLOW_RATE = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SLOW_BIAS = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_ONSET_GAIN = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_SMOOTH_EN = 3'd6;

	typedef logic [ENV_W-1:0] env_t;

endpackage

`default_nettype wire

@@ rtl/dual_envelope_onset_follower_top.sv @@
// Channel   Direction  Handshake           Payload
// input     in         in_valid/in_stall   command, mean_amplitude
// result    out        out_valid/out_stall onset_level
// config    in         cfg_we              cfg_index, cfg_data
//
// An update transaction that needs the divider runs a restoring division, one quotient bit per
// cycle, then a sequence of steps on the shared multiplier before the result register loads.
// A level that saturates skips the division, and a clear goes straight to the output state.
// Input is accepted only in idle; a result waiting in the output register does not block it.
// Reset loads the register defaults and zeroes all three envelopes.
`default_nettype none
`include "assert_macros.svh"

module dual_envelope_onset_follower_top (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic                           command,
	input  logic [deof_pkg::AMP_W-1:0]     mean_amplitude,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [deof_pkg::OUT_W-1:0]     onset_level,
	input  logic                           cfg_we,
	input  logic [deof_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [deof_pkg::CFG_DATA_W-1:0] cfg_data
);
	import deof_pkg::*;

	localparam logic [3:0] ST_IDLE   = 4'd0;
	localparam logic [3:0] ST_DIV    = 4'd1;
	localparam logic [3:0] ST_FAST   = 4'd2;
	localparam logic [3:0] ST_SLOW   = 4'd3;
	localparam logic [3:0] ST_SLOWUP = 4'd4;
	localparam logic [3:0] ST_BIAS   = 4'd5;
	localparam logic [3:0] ST_DIFF   = 4'd6;
	localparam logic [3:0] ST_GAIN   = 4'd7;
	localparam logic [3:0] ST_ONSET  = 4'd8;
	localparam logic [3:0] ST_SMO    = 4'd9;
	localparam logic [3:0] ST_SMN    = 4'd10;
	localparam logic [3:0] ST_SMSUM  = 4'd11;
	localparam logic [3:0] ST_OUT    = 4'd12;

	logic [3:0]                 state_q;
	logic [AMP_W-1:0]           level_scale_q;
	logic [RATE_W-1:0]          fast_rise_q;
	logic [RATE_W-1:0]          fast_fall_q;
	logic [RATE_W-1:0]          slow_rate_q;
	logic [BIAS_W-1:0]          slow_bias_q;
	logic [GAIN_W-1:0]          onset_gain_q;
	logic                       smooth_en_q;

	env_t                       fast_q;
	env_t                       slow_q;
	env_t                       sm_q;
	env_t                       level_q;
	env_t                       onset_q;
	logic [AMP_W-1:0]           rem_q;
	logic [CNT_W-1:0]           cnt_q;
	logic signed [PROD_W-1:0]   prod_q;
	logic signed [MUL_A_W-1:0]  diff_q;
	logic [ACC_W-2:0]           acc_q;
	logic                       out_valid_q;
	logic [OUT_W-1:0]           onset_level_q;

	logic [AMP_W-1:0]           scale_eff;
	logic                       in_take;
	logic [AMP_W:0]             rem2;
	logic                       rem_ge;
	logic [AMP_W:0]             rem_sub;
	logic signed [ENV_W:0]      env_diff;
	logic signed [MUL_A_W-1:0]  mul_a;
	logic signed [MUL_B_W-1:0]  mul_b;
	logic signed [PROD_W-1:0]   prod_c;
	env_t                       env_in;
	logic signed [PROD_W-1:0]   step_full;
	logic signed [ENV_W:0]      step_s;
	logic [ENV_W:0]             env_sum;
	env_t                       env_new;
	logic signed [MUL_A_W-1:0]  diff_c;
	logic [PROD_W-1:0]          gain_rnd;
	logic [PROD_W-GAIN_SHIFT-1:0] gain_res;
	env_t                       onset_c;
	logic [ACC_W-1:0]           smooth_sum;
	logic                       out_free;

	assign scale_eff = (level_scale_q == '0) ? AMP_W'(1) : level_scale_q;
	assign in_stall = (state_q != ST_IDLE);
	assign in_take = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;
	assign onset_level = onset_level_q;

	assign rem2 = {rem_q, 1'b0};
	assign rem_ge = (rem2 >= {1'b0, scale_eff});
	assign rem_sub = rem2 - {1'b0, scale_eff};

	always_comb begin
		env_in = (state_q == ST_SLOW) ? fast_q : slow_q;
		env_diff = $signed({1'b0, level_q}) - $signed({1'b0, (state_q == ST_FAST) ? fast_q : slow_q});
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_FAST: begin
				mul_a = {{(MUL_A_W-ENV_W-1){env_diff[ENV_W]}}, env_diff};
				mul_b = {2'b00, (level_q > fast_q) ? fast_rise_q : fast_fall_q};
			end
			ST_SLOW: begin
				mul_a = {{(MUL_A_W-ENV_W-1){env_diff[ENV_W]}}, env_diff};
				mul_b = {2'b00, slow_rate_q};
			end
			ST_BIAS: begin
				mul_a = {{(MUL_A_W-ENV_W){1'b0}}, slow_q};
				mul_b = {3'b000, slow_bias_q};
			end
			ST_GAIN: begin
				mul_a = diff_q;
				mul_b = {2'b00, onset_gain_q};
			end
			ST_SMO: begin
				mul_a = {{(MUL_A_W-ENV_W){1'b0}}, sm_q};
				mul_b = {2'b00, SMOOTH_OLD};
			end
			ST_SMN: begin
				mul_a = {{(MUL_A_W-ENV_W){1'b0}}, onset_q};
				mul_b = {2'b00, SMOOTH_NEW};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign prod_c = mul_a * mul_b;

	assign step_full = (prod_q + PROD_W'(1 << (RATE_FRAC - 1))) >>> RATE_FRAC;
	assign step_s = step_full[ENV_W:0];
	assign env_sum = {1'b0, env_in} + step_s;
	assign env_new = env_sum[ENV_W-1:0];

	assign diff_c = $signed({2'b00, fast_q, {BIAS_FRAC{1'b0}}})
		- $signed({2'b00, prod_q[MUL_A_W-3:0]});

	assign gain_rnd = prod_q + PROD_W'(1 << (GAIN_SHIFT - 1));
	assign gain_res = gain_rnd[PROD_W-1:GAIN_SHIFT];

	always_comb begin
		if (diff_q[MUL_A_W-1] || (diff_q == '0)) begin
			onset_c = '0;
		end else if (gain_res > (PROD_W-GAIN_SHIFT)'(UNIT_LEVEL)) begin
			onset_c = UNIT_LEVEL;
		end else begin
			onset_c = gain_res[ENV_W-1:0];
		end
	end

	assign smooth_sum = {1'b0, acc_q} + {1'b0, prod_q[ACC_W-2:0]}
		+ ACC_W'(1 << (SMOOTH_SHIFT - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_scale_q <= 16'd7200;
			fast_rise_q <= 16'd18350;
			fast_fall_q <= 16'd18350;
			slow_rate_q <= 16'd3932;
			slow_bias_q <= 15'd16384;
			onset_gain_q <= 16'd13107;
			smooth_en_q <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_LEVEL_SCALE: level_scale_q <= cfg_data;
				REG_FAST_RISE: fast_rise_q <= cfg_data;
				REG_FAST_FALL: fast_fall_q <= cfg_data;
				REG_SLOW_RATE: slow_rate_q <= cfg_data;
				REG_SLOW_BIAS: slow_bias_q <= cfg_data[BIAS_W-1:0];
				REG_ONSET_GAIN: onset_gain_q <= cfg_data;
				REG_SMOOTH_EN: smooth_en_q <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			fast_q <= '0;
			slow_q <= '0;
			sm_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if ((state_q == ST_OUT) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_take) begin
						if (command == CMD_CLEAR) begin
							fast_q <= '0;
							slow_q <= '0;
							sm_q <= '0;
							state_q <= ST_OUT;
						end else if (mean_amplitude >= scale_eff) begin
							level_q <= UNIT_LEVEL;
							state_q <= ST_FAST;
						end else begin
							rem_q <= mean_amplitude;
							level_q <= '0;
							cnt_q <= CNT_W'(FRAC_BITS - 1);
							state_q <= ST_DIV;
						end
					end
				end
				ST_DIV: begin
					rem_q <= rem_ge ? rem_sub[AMP_W-1:0] : rem2[AMP_W-1:0];
					level_q <= {level_q[ENV_W-2:0], rem_ge};
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0) begin
						state_q <= ST_FAST;
					end
				end
				ST_FAST: begin
					prod_q <= prod_c;
					state_q <= ST_SLOW;
				end
				ST_SLOW: begin
					fast_q <= env_new;
					prod_q <= prod_c;
					state_q <= ST_SLOWUP;
				end
				ST_SLOWUP: begin
					slow_q <= env_new;
					state_q <= ST_BIAS;
				end
				ST_BIAS: begin
					prod_q <= prod_c;
					state_q <= ST_DIFF;
				end
				ST_DIFF: begin
					diff_q <= diff_c;
					state_q <= ST_GAIN;
				end
				ST_GAIN: begin
					prod_q <= prod_c;
					state_q <= ST_ONSET;
				end
				ST_ONSET: begin
					onset_q <= onset_c;
					if (smooth_en_q) begin
						state_q <= ST_SMO;
					end else begin
						sm_q <= onset_c;
						state_q <= ST_OUT;
					end
				end
				ST_SMO: begin
					prod_q <= prod_c;
					state_q <= ST_SMN;
				end
				ST_SMN: begin
					acc_q <= prod_q[ACC_W-2:0];
					prod_q <= prod_c;
					state_q <= ST_SMSUM;
				end
				ST_SMSUM: begin
					sm_q <= smooth_sum[SMOOTH_SHIFT+ENV_W-1:SMOOTH_SHIFT];
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_free) begin
						onset_level_q <= sm_q;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// A result transaction appears only when the sequencer leaves its output state.
	`DEOF_ASSERT(a_out_from_seq, $rose(out_valid_q) |-> $past(state_q == ST_OUT))
	// The envelopes and the smoothed onset never pass 1.0.
	`DEOF_ASSERT_NEVER(a_env_range, (fast_q > UNIT_LEVEL) || (slow_q > UNIT_LEVEL) || (sm_q > UNIT_LEVEL))
	// The partial remainder stays below the divisor during the division.
	`DEOF_ASSERT(a_rem_below, (state_q == ST_DIV) |-> (rem_q < scale_eff))
	// A clear transaction produces a zero result.
	`DEOF_ASSERT(a_clear_zero, (in_take && (command == CMD_CLEAR)) |=> (sm_q == '0) && (state_q == ST_OUT))

endmodule

`default_nettype wire

@@ sim/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
	import deof_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
	localparam int PHASE_ITEMS = 72;
	localparam int PHASES = 6;
	localparam longint UNIT = longint'(UNIT_LEVEL);

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic command;
	logic [AMP_W-1:0] mean_amplitude;
	logic out_valid;
	logic out_stall;
	logic [OUT_W-1:0] onset_level;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	logic [CFG_DATA_W-1:0] div_scale, rise_coef, fall_coef, slow_coef, diff_gain;
	logic [BIAS_W-1:0] slow_weight;
	logic smoothing_on;
	env_t fast_env, slow_env, smooth_env;

	logic [OUT_W-1:0] expected_onsets[$];
	int mismatches = 0;
	int results_checked = 0;
	int items_sent = 0;
	int clears_sent = 0;
	int reg_writes = 0;
	int reg_settings = 0;
	int long_holds = 0;
	int hold_request = 0;
	bit tx_quiet = 1'b0;
	bit rx_quiet = 1'b0;

	dual_envelope_onset_follower_top DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.command(command),
		.mean_amplitude(mean_amplitude),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.onset_level(onset_level),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #6 clk = ~clk;

	function automatic void restore_power_on_state();
		div_scale = 16'd7200;
		rise_coef = 16'd18350;
		fall_coef = 16'd18350;
		slow_coef = 16'd3932;
		slow_weight = 15'd16384;
		diff_gain = 16'd13107;
		smoothing_on = 1'b1;
		fast_env = '0;
		slow_env = '0;
		smooth_env = '0;
	endfunction

	function automatic longint follow_level(input longint env, input longint target,
			input longint coef);
		return env + (((target - env) * coef + (longint'(1) <<< (RATE_FRAC - 1))) >>> RATE_FRAC);
	endfunction

	function automatic logic [OUT_W-1:0] advance_envelopes(input logic cmd,
			input logic [AMP_W-1:0] amp);
		longint level, coef, diff, onset, divisor;
		if (cmd == CMD_CLEAR) begin
			fast_env = '0;
			slow_env = '0;
			smooth_env = '0;
			return '0;
		end
		divisor = (div_scale == '0) ? longint'(1) : longint'(div_scale);
		level = (longint'(amp) <<< FRAC_BITS) / divisor;
		if (level > UNIT)
			level = UNIT;
		coef = (level > longint'(fast_env)) ? longint'(rise_coef) : longint'(fall_coef);
		fast_env = env_t'(follow_level(longint'(fast_env), level, coef));
		slow_env = env_t'(follow_level(longint'(slow_env), level, longint'(slow_coef)));
		diff = (longint'(fast_env) <<< BIAS_FRAC) - longint'(slow_env) * longint'(slow_weight);
		if (diff <= 0) begin
			onset = 0;
		end else begin
			onset = (diff * longint'(diff_gain) + (longint'(1) <<< (GAIN_SHIFT - 1))) >>> GAIN_SHIFT;
			if (onset > UNIT)
				onset = UNIT;
		end
		if (smoothing_on)
			smooth_env = env_t'((longint'(smooth_env) * longint'(SMOOTH_OLD)
				+ onset * longint'(SMOOTH_NEW)
				+ (longint'(1) <<< (SMOOTH_SHIFT - 1))) >>> SMOOTH_SHIFT);
		else
			smooth_env = env_t'(onset);
		return smooth_env;
	endfunction

	function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		case (idx)
			REG_LEVEL_SCALE: div_scale = data;
			REG_FAST_RISE: rise_coef = data;
			REG_FAST_FALL: fall_coef = data;
			REG_SLOW_RATE: slow_coef = data;
			REG_SLOW_BIAS: slow_weight = data[BIAS_W-1:0];
			REG_ONSET_GAIN: diff_gain = data;
			REG_SMOOTH_EN: smoothing_on = data[0];
			default: ;
		endcase
	endfunction

	task automatic report_mismatch(input string what, input logic [OUT_W-1:0] got,
			input logic [OUT_W-1:0] want);
		mismatches++;
		$display("%0t ns: %s: got %0d, expected %0d", $time, what, got, want);
	endtask

	task automatic check_onset(input logic [OUT_W-1:0] got);
		logic [OUT_W-1:0] want;
		if (expected_onsets.size() == 0) begin
			report_mismatch("result with no transaction pending", got, '0);
		end else begin
			want = expected_onsets.pop_front();
			results_checked++;
			if (got !== want)
				report_mismatch("onset_level", got, want);
		end
	endtask

	// The receiver stalls for a drawn pause after each result, none while quiet.
	initial begin : result_receiver
		int pause;
		pause = 0;
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (out_valid === 1'b1 && !out_stall) begin
				check_onset(onset_level);
				pause = rx_quiet ? 0 : $urandom_range(0, 10);
			end else if (pause > 0) begin
				pause--;
			end
			if (hold_request > 0) begin
				pause = hold_request;
				hold_request = 0;
				long_holds++;
			end
			out_stall <= (pause > 0);
		end
	end

	task automatic send_item(input logic cmd, input logic [AMP_W-1:0] amp);
		int gap;
		gap = tx_quiet ? 0 : $urandom_range(0, 10);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		command <= cmd;
		mean_amplitude <= amp;
		@(posedge clk);
		while (in_stall !== 1'b0)
			@(posedge clk);
		expected_onsets.push_back(advance_envelopes(cmd, amp));
		items_sent++;
		if (cmd == CMD_CLEAR)
			clears_sent++;
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (expected_onsets.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic program_regs(input logic [REG_SMOOTH_EN:0][CFG_DATA_W-1:0] values,
			input bit with_unused);
		for (int i = REG_LEVEL_SCALE; i <= REG_SMOOTH_EN; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= CFG_IDX_W'(i);
			cfg_data <= values[i];
			@(posedge clk);
			apply_reg(CFG_IDX_W'(i), values[i]);
			reg_writes++;
		end
		if (with_unused) begin
			cfg_index <= REG_UNUSED;
			cfg_data <= CFG_DATA_W'($urandom);
			@(posedge clk);
			reg_writes++;
		end
		cfg_we <= 1'b0;
		@(posedge clk);
		reg_settings++;
	endtask

	function automatic logic [CFG_DATA_W-1:0] draw_coef();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return '1;
			default: return CFG_DATA_W'($urandom);
		endcase
	endfunction

	function automatic logic [CFG_DATA_W-1:0] draw_scale();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return 16'd1;
			2: return 16'h8000;
			default: return CFG_DATA_W'($urandom_range(1, 32768));
		endcase
	endfunction

	function automatic logic [AMP_W-1:0] draw_amplitude();
		int unsigned sel, top;
		sel = $urandom_range(0, 99);
		top = (div_scale == '0) ? 1 : div_scale;
		top = top + top / 4;
		if (top > 65535)
			top = 65535;
		if (sel < 70)
			return AMP_W'($urandom_range(0, top));
		else if (sel < 90)
			return AMP_W'($urandom);
		case ($urandom_range(0, 3))
			0: return '0;
			1: return '1;
			2: return div_scale;
			default: return 16'h8000;
		endcase
	endfunction

	task automatic test_default_settings();
		send_item(CMD_UPDATE, 16'd0);
		send_item(CMD_UPDATE, 16'd7200);
		send_item(CMD_UPDATE, 16'hFFFF);
		send_item(CMD_UPDATE, 16'h8000);
		send_item(CMD_UPDATE, 16'd3600);
		send_item(CMD_UPDATE, 16'd0);
		send_item(CMD_UPDATE, 16'd0);
		send_item(CMD_CLEAR, 16'hFFFF);
		send_item(CMD_UPDATE, 16'd1);
		send_item(CMD_CLEAR, 16'd0);
		wait_idle();
	endtask

	task automatic test_register_extremes();
		logic [REG_SMOOTH_EN:0][CFG_DATA_W-1:0] values;
		// A zero divisor acts as one; heavy bias first keeps the difference negative.
		values[REG_LEVEL_SCALE] = '0;
		values[REG_FAST_RISE] = '1;
		values[REG_FAST_FALL] = '0;
		values[REG_SLOW_RATE] = '1;
		values[REG_SLOW_BIAS] = 16'h7FFF;
		values[REG_ONSET_GAIN] = '1;
		values[REG_SMOOTH_EN] = '0;
		program_regs(values, 1'b1);
		send_item(CMD_UPDATE, 16'd1);
		send_item(CMD_UPDATE, 16'd2);
		send_item(CMD_UPDATE, 16'd0);
		send_item(CMD_UPDATE, 16'hFFFF);
		send_item(CMD_UPDATE, 16'hFFFF);
		send_item(CMD_UPDATE, 16'd0);
		wait_idle();
		values[REG_LEVEL_SCALE] = 16'h8000;
		values[REG_FAST_RISE] = '0;
		values[REG_FAST_FALL] = '1;
		values[REG_SLOW_RATE] = '0;
		values[REG_SLOW_BIAS] = '0;
		values[REG_ONSET_GAIN] = '0;
		values[REG_SMOOTH_EN] = 16'd1;
		program_regs(values, 1'b1);
		send_item(CMD_UPDATE, 16'hFFFF);
		send_item(CMD_UPDATE, 16'h8000);
		send_item(CMD_UPDATE, 16'h4000);
		send_item(CMD_UPDATE, 16'd1);
		send_item(CMD_UPDATE, 16'd0);
		send_item(CMD_CLEAR, 16'h5A5A);
		wait_idle();
		// Full gain with a light bias drives the onset into its upper clamp.
		values[REG_LEVEL_SCALE] = 16'd4096;
		values[REG_FAST_RISE] = '1;
		values[REG_FAST_FALL] = 16'h0100;
		values[REG_SLOW_RATE] = 16'h0400;
		values[REG_SLOW_BIAS] = 16'h2000;
		values[REG_ONSET_GAIN] = '1;
		values[REG_SMOOTH_EN] = '0;
		program_regs(values, 1'b0);
		send_item(CMD_UPDATE, 16'd4096);
		send_item(CMD_UPDATE, 16'd2048);
		send_item(CMD_UPDATE, 16'd0);
		wait_idle();
	endtask

	task automatic test_random_settings();
		logic [REG_SMOOTH_EN:0][CFG_DATA_W-1:0] values;
		logic [AMP_W-1:0] amp;
		int sent, run;
		for (int p = 0; p < PHASES; p++) begin
			values[REG_LEVEL_SCALE] = draw_scale();
			values[REG_FAST_RISE] = draw_coef();
			values[REG_FAST_FALL] = draw_coef();
			values[REG_SLOW_RATE] = draw_coef();
			values[REG_SLOW_BIAS] = draw_coef() & 16'h7FFF;
			values[REG_ONSET_GAIN] = draw_coef();
			values[REG_SMOOTH_EN] = CFG_DATA_W'($urandom_range(0, 1));
			program_regs(values, p % 2 == 0);
			tx_quiet = (p < 2);
			rx_quiet = (p == 0 || p == 2);
			sent = 0;
			while (sent < PHASE_ITEMS) begin
				// Runs of one amplitude let the envelopes settle before the next step.
				run = $urandom_range(1, 8);
				amp = draw_amplitude();
				repeat (run) begin
					if ($urandom_range(0, 24) == 0)
						send_item(CMD_CLEAR, AMP_W'($urandom));
					else
						send_item(CMD_UPDATE, amp);
					sent++;
				end
			end
			wait_idle();
		end
		tx_quiet = 1'b0;
		rx_quiet = 1'b0;
	endtask

	task automatic test_output_backpressure();
		tx_quiet = 1'b1;
		rx_quiet = 1'b1;
		hold_request = 300;
		repeat (12) send_item(CMD_UPDATE, draw_amplitude());
		wait_idle();
		tx_quiet = 1'b0;
		rx_quiet = 1'b0;
	endtask

	initial begin
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		command <= CMD_UPDATE;
		mean_amplitude <= '0;
		cfg_we <= 1'b0;
		cfg_index <= REG_LEVEL_SCALE;
		cfg_data <= '0;
		restore_power_on_state();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_default_settings();
		test_register_extremes();
		test_random_settings();
		test_output_backpressure();
		repeat (40) @(posedge clk);
		$display("Sent %0d transactions (%0d clears) under %0d register settings, %0d writes.",
			items_sent, clears_sent, reg_settings, reg_writes);
		$display("Checked %0d results with %0d long output hold-offs; %0d mismatches.",
			results_checked, long_holds, mismatches);
		if (mismatches == 0 && expected_onsets.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	initial begin
		#3_000_000;
		$display("Timeout with %0d results still outstanding.", expected_onsets.size());
		$display("*** FAILED ***");
		$finish;
	end

endmodule
